@@ hw/rtl/wthf_pkg.sv @@
// Shared types and constants for the windowed threshold fraction block.
package wthf_pkg;

	localparam int SampleW  = 20;
	localparam int RowW     = 20;
	localparam int HitsW    = 9;
	localparam int SumW     = 15;
	localparam int PctW     = 15;
	localparam int SprW     = 9;
	localparam int WinW     = 7;
	localparam int HopW     = 6;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 20;
	localparam int DvdW     = 30;
	localparam int DvsW     = 16;
	localparam int DivSteps = 30;
	localparam int DivCntW  = 5;

	localparam logic [RowW-1:0]  RowMax   = 20'hFFFFF;
	localparam logic [DvdW-1:0]  PctScale = 30'd25600;
	localparam logic [HitsW-1:0] HitsMax  = 9'h1FF;

	localparam logic [CfgIdxW-1:0] CFG_COUNT_BELOW     = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_THRESHOLD       = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_SAMPLES_PER_ROW = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_WINDOW_ROWS     = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_HOP_ROWS        = 3'd4;
	localparam logic [CfgIdxW-1:0] CFG_RECORD_ROWS     = 3'd5;

	typedef struct packed {
		logic signed [SampleW-1:0] sample;
		logic                      first_of_log;
	} smp_t;

	typedef struct packed {
		logic [PctW-1:0] window_percent;
		logic [RowW-1:0] window_start_row;
	} res_t;

	typedef struct packed {
		logic take;
		logic rd_issue;
		logic mul;
		logic div_step;
		logic load_out;
	} wthf_cmd_t;

	typedef struct packed {
		logic emit;
		logic rd_last;
		logic div_last;
	} wthf_sts_t;

endpackage

@@ hw/rtl/wthf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module wthf_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hw/rtl/wthf_ctrl.sv @@
// Controller state machine: item intake, window sum, divide and result hand-off.
module wthf_ctrl import wthf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      smp_valid,
	output logic      smp_stall,
	output logic      res_valid,
	input  logic      res_stall,
	output wthf_cmd_t cmd,
	input  wthf_sts_t sts
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_READ  = 6'b000010,
		S_DRAIN = 6'b000100,
		S_MUL   = 6'b001000,
		S_DIV   = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   res_valid_q;
	logic   out_free;

	assign out_free  = !res_valid_q || !res_stall;
	assign smp_stall = (state_q != S_IDLE);
	assign res_valid = res_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.take = smp_valid;
				if (smp_valid && sts.emit) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				cmd.rd_issue = 1'b1;
				if (sts.rd_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ hw/rtl/wthf_dp.sv @@
// Datapath: configuration, row counting, row-count ring, window sum and divider.
module wthf_dp import wthf_pkg::*; #(
	parameter int MAX_COLS = 256,
	parameter int MAX_WIN  = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  smp_t                smp,
	output res_t                res,
	input  wthf_cmd_t           cmd,
	output wthf_sts_t           sts
);

	localparam int AW     = $clog2(MAX_WIN);
	localparam int ColCap = (MAX_COLS < 511) ? MAX_COLS : 511;
	localparam int WinCap = (MAX_WIN < 127) ? MAX_WIN : 127;

	logic                      cb_q;
	logic signed [SampleW-1:0] thr_q;
	logic [SprW-1:0]           spr_q;
	logic [WinW-1:0]           wr_q;
	logic [HopW-1:0]           hr_q;
	logic [RowW-1:0]           rec_q;

	logic [HitsW-1:0]   hits_q;
	logic [SprW-1:0]    col_q;
	logic [RowW-1:0]    row_q;
	logic [AW-1:0]      slot_q;
	logic [RowW-1:0]    nws_q;
	logic [RowW-1:0]    start_q;
	logic [SumW-1:0]    sum_q;
	logic [AW-1:0]      rd_ptr_q;
	logic [WinW-1:0]    rd_cnt_q;
	logic               rd_pend_s1;
	logic [DvdW-1:0]    dvd_q;
	logic [DvsW:0]      rem_q;
	logic [DvsW-1:0]    dvs_q;
	logic [DivCntW-1:0] div_cnt_q;
	res_t               res_q;

	logic [SprW-1:0]           n_eff;
	logic [WinW-1:0]           w_eff;
	logic [WinW-1:0]           w_m1;
	logic [HopW-1:0]           h_eff;
	logic signed [SampleW-1:0] s_val;
	logic                      hit;
	logic [HitsW-1:0]          hits_b, hits_n;
	logic [SprW-1:0]           col_b;
	logic [RowW-1:0]           row_b, row_n;
	logic [AW-1:0]             slot_b, slot_n;
	logic [RowW-1:0]           nws_b, nws_adv;
	logic [RowW:0]             nws_sum, win_end;
	logic                      row_end;
	logic                      emit;
	logic [HitsW-1:0]          rdata;
	logic [DvsW:0]             rem_sh;
	logic                      ge;

	always_comb begin
		n_eff = spr_q;
		if (spr_q == '0) begin
			n_eff = SprW'(1);
		end else if (spr_q > SprW'(ColCap)) begin
			n_eff = SprW'(ColCap);
		end
		w_eff = wr_q;
		if (wr_q < WinW'(2)) begin
			w_eff = WinW'(2);
		end else if (wr_q > WinW'(WinCap)) begin
			w_eff = WinW'(WinCap);
		end
		w_m1  = w_eff - WinW'(1);
		h_eff = hr_q;
		if (hr_q == '0) begin
			h_eff = HopW'(1);
		end else if ({1'b0, hr_q} > w_m1) begin
			h_eff = w_m1[HopW-1:0];
		end
	end

	always_comb begin
		s_val  = smp.sample;
		hit    = cb_q ? (s_val < thr_q) : (s_val > thr_q);
		hits_b = smp.first_of_log ? '0 : hits_q;
		col_b  = smp.first_of_log ? '0 : col_q;
		row_b  = smp.first_of_log ? '0 : row_q;
		slot_b = smp.first_of_log ? '0 : slot_q;
		nws_b  = smp.first_of_log ? '0 : nws_q;
		hits_n = (hit && hits_b != HitsMax) ? hits_b + HitsW'(1) : hits_b;
		row_end = ({1'b0, col_b} + (SprW+1)'(1)) >= {1'b0, n_eff};
		row_n  = (row_b < RowMax) ? row_b + RowW'(1) : row_b;
		slot_n = slot_b;
		if (row_b < RowMax) begin
			slot_n = (slot_b == AW'(MAX_WIN - 1)) ? '0 : slot_b + AW'(1);
		end
		win_end = {1'b0, nws_b} + (RowW+1)'(w_eff);
		emit    = row_end && (({1'b0, row_b} + (RowW+1)'(1)) == win_end)
			&& (win_end < {1'b0, rec_q});
		nws_sum = {1'b0, nws_b} + (RowW+1)'(h_eff);
		nws_adv = (nws_sum > {1'b0, RowMax}) ? RowMax : nws_sum[RowW-1:0];
	end

	assign rem_sh = {rem_q[DvsW-1:0], dvd_q[DvdW-1]};
	assign ge     = rem_sh >= {1'b0, dvs_q};

	assign sts.emit     = emit;
	assign sts.rd_last  = (rd_cnt_q == w_m1);
	assign sts.div_last = (div_cnt_q == DivCntW'(DivSteps - 1));
	assign res          = res_q;

	wthf_ram #(
		.WIDTH(HitsW),
		.DEPTH(MAX_WIN)
	) u_ring (
		.clk  (clk),
		.we   (cmd.take && row_end),
		.waddr(slot_b),
		.wdata(hits_n),
		.re   (cmd.rd_issue),
		.raddr(rd_ptr_q),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cb_q  <= 1'b0;
			thr_q <= 20'sd48384;
			spr_q <= 9'd256;
			wr_q  <= 7'd4;
			hr_q  <= 6'd1;
			rec_q <= RowMax;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_COUNT_BELOW:     cb_q  <= cfg_data[0];
				CFG_THRESHOLD:       thr_q <= cfg_data;
				CFG_SAMPLES_PER_ROW: spr_q <= cfg_data[SprW-1:0];
				CFG_WINDOW_ROWS:     wr_q  <= cfg_data[WinW-1:0];
				CFG_HOP_ROWS:        hr_q  <= cfg_data[HopW-1:0];
				CFG_RECORD_ROWS:     rec_q <= cfg_data[RowW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q     <= '0;
			col_q      <= '0;
			row_q      <= '0;
			slot_q     <= '0;
			nws_q      <= '0;
			rd_pend_s1 <= 1'b0;
		end else begin
			rd_pend_s1 <= cmd.rd_issue;
			if (cmd.take) begin
				if (row_end) begin
					hits_q <= '0;
					col_q  <= '0;
					row_q  <= row_n;
					slot_q <= slot_n;
				end else begin
					hits_q <= hits_n;
					col_q  <= col_b + SprW'(1);
					row_q  <= row_b;
					slot_q <= slot_b;
				end
				nws_q <= emit ? nws_adv : nws_b;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && emit) begin
			start_q  <= nws_b;
			rd_ptr_q <= slot_b;
			rd_cnt_q <= '0;
			sum_q    <= '0;
		end else begin
			if (cmd.rd_issue) begin
				rd_ptr_q <= (rd_ptr_q == '0) ? AW'(MAX_WIN - 1) : rd_ptr_q - AW'(1);
				rd_cnt_q <= rd_cnt_q + WinW'(1);
			end
			if (rd_pend_s1) begin
				sum_q <= sum_q + SumW'(rdata);
			end
		end
		if (cmd.mul) begin
			dvd_q     <= DvdW'(sum_q) * PctScale;
			dvs_q     <= DvsW'(n_eff) * DvsW'(w_eff);
			rem_q     <= '0;
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q     <= ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
			dvd_q     <= {dvd_q[DvdW-2:0], ge};
			div_cnt_q <= div_cnt_q + DivCntW'(1);
		end
		if (cmd.load_out) begin
			res_q.window_percent   <= dvd_q[PctW-1:0];
			res_q.window_start_row <= start_q;
		end
	end

endmodule

@@ hw/rtl/windowed_threshold_fraction.sv @@
// Top level of the windowed threshold fraction block.
// A sample that does not close a reporting window is taken without a stall; back-to-back.
// A sample that closes a window stalls intake for one ring read per window row, then
// a drain, a multiply, a 30-step restoring divide and the result load.
// Its result is loaded once the divide is done and the previous result has been taken.
// Reset clears control and restores configuration defaults; the ring is not cleared.
module windowed_threshold_fraction import wthf_pkg::*; #(
	parameter int MAX_COLS = 256,
	parameter int MAX_WIN  = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                smp_valid,
	output logic                smp_stall,
	input  smp_t                smp,
	output logic                res_valid,
	input  logic                res_stall,
	output res_t                res,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	wthf_cmd_t cmd;
	wthf_sts_t sts;

	assign cfg_ready = 1'b1;

	wthf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.smp_valid(smp_valid),
		.smp_stall(smp_stall),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	wthf_dp #(
		.MAX_COLS(MAX_COLS),
		.MAX_WIN (MAX_WIN)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.smp      (smp),
		.res      (res),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule

@@ hw/rtl/wthf_chk.sv @@
// Port-level checker for the windowed threshold fraction block, with its bind.
module wthf_chk import wthf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic smp_valid,
	input logic smp_stall,
	input logic res_valid,
	input logic res_stall,
	input res_t res
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	a_res_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(smp_stall))
		else $error("result appeared without a busy period");

	a_busy_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(smp_stall) |-> $past(smp_valid && !smp_stall))
		else $error("intake stalled without a taken item");

	a_busy_length: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(smp_stall) |-> ##DivSteps smp_stall)
		else $error("intake released before the divide could finish");

endmodule

bind windowed_threshold_fraction wthf_chk u_wthf_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.smp_valid(smp_valid),
	.smp_stall(smp_stall),
	.res_valid(res_valid),
	.res_stall(res_stall),
	.res      (res)
);
